/* src/barometric_pressure_compensation_macros.svh */
// Assertion macros for the pressure compensation checker
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/bpc_pkg.sv */
// Shared types and constants for the barometric pressure compensation block
package bpc_pkg;

    localparam int unsigned CAL_WIDTH       = 16;
    localparam int unsigned RAW_WIDTH       = 24;
    localparam int unsigned TEMP_WIDTH      = 19;
    localparam int unsigned PRES_WIDTH      = 32;
    localparam int unsigned CFG_INDEX_WIDTH = 3;
    localparam int unsigned PIPE_DEPTH      = 10;

    // Temperature reference (20.00 degC) and the cold-branch threshold (-15.00 degC),
    // the latter expressed relative to the reference
    localparam logic signed [19:0] TEMP_REF     = 20'sd2000;
    localparam logic signed [17:0] FRIGID_LIMIT = -18'sd3500;
    localparam logic signed [18:0] FRIGID_BIAS  = 19'sd3500;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PRESSURE_SENSITIVITY  = 3'd0,
        REG_PRESSURE_OFFSET       = 3'd1,
        REG_SENSITIVITY_TEMP_COEF = 3'd2,
        REG_OFFSET_TEMP_COEF      = 3'd3,
        REG_REFERENCE_TEMPERATURE = 3'd4,
        REG_TEMPERATURE_COEF      = 3'd5
    } cal_index_t;

    typedef struct packed {
        logic [CAL_WIDTH-1:0] pressure_sensitivity;
        logic [CAL_WIDTH-1:0] pressure_offset;
        logic [CAL_WIDTH-1:0] sensitivity_temp_coef;
        logic [CAL_WIDTH-1:0] offset_temp_coef;
        logic [CAL_WIDTH-1:0] reference_temperature;
        logic [CAL_WIDTH-1:0] temperature_coef;
    } cal_t;

endpackage

/* src/bpc_cfg.sv */
// Calibration word register file
module bpc_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0]  wr_index,
    input  logic [bpc_pkg::CAL_WIDTH-1:0]        wr_data,
    output bpc_pkg::cal_t                        cal
);

    bpc_pkg::cal_t cal_reg;
    bpc_pkg::cal_t cal_next;

    // Decode the write request; drop writes to unused indexes
    always_comb
    begin
        cal_next = cal_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                bpc_pkg::REG_PRESSURE_SENSITIVITY:  cal_next.pressure_sensitivity  = wr_data;
                bpc_pkg::REG_PRESSURE_OFFSET:       cal_next.pressure_offset       = wr_data;
                bpc_pkg::REG_SENSITIVITY_TEMP_COEF: cal_next.sensitivity_temp_coef = wr_data;
                bpc_pkg::REG_OFFSET_TEMP_COEF:      cal_next.offset_temp_coef      = wr_data;
                bpc_pkg::REG_REFERENCE_TEMPERATURE: cal_next.reference_temperature = wr_data;
                bpc_pkg::REG_TEMPERATURE_COEF:      cal_next.temperature_coef      = wr_data;
                default:                            cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    assign cal = cal_reg;

endmodule

/* src/barometric_pressure_compensation.sv */
// Top level: second-order pressure and temperature compensation pipeline
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//  in       in         in_valid / in_ready    raw_pressure, raw_temperature
//  out      out        out_valid / out_ready  temperature_centi, pressure_centi
//
// One reading pair enters per cycle while in_ready is high; each result passes through
// the ten register stages around the multipliers and wide adders.
// cfg_ready is always high; a write is registered and lands in the next cycle.
// Reset clears the calibration words and all stage valid bits.
// Each stage holds while the next one is full and stalled, so empty stages close up
// and requests are still taken while a result waits at the output and a stage is empty.
module barometric_pressure_compensation (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [bpc_pkg::CFG_INDEX_WIDTH-1:0]         cfg_index,
    input  logic [bpc_pkg::CAL_WIDTH-1:0]               cfg_data,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [bpc_pkg::RAW_WIDTH-1:0]               raw_pressure,
    input  logic [bpc_pkg::RAW_WIDTH-1:0]               raw_temperature,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic signed [bpc_pkg::TEMP_WIDTH-1:0]       temperature_centi,
    output logic signed [bpc_pkg::PRES_WIDTH-1:0]       pressure_centi
);

    localparam int unsigned DEPTH = bpc_pkg::PIPE_DEPTH;

    bpc_pkg::cal_t cal;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [DEPTH-1:0] advance;
    logic [DEPTH-1:0] load;

    // Calibration words
    assign cfg_ready = 1'b1;

    bpc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cal      (cal)
    );

    // Stage control: a stage advances when empty or when the stage after it advances
    always_comb
    begin
        advance[DEPTH-1] = !valid_reg[DEPTH-1] || out_ready;
        for (int k = DEPTH - 2; k >= 0; k--)
        begin
            advance[k] = !valid_reg[k] || advance[k+1];
        end
        load[0]       = advance[0] && in_valid;
        valid_next[0] = advance[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < DEPTH; k++)
        begin
            load[k]       = advance[k] && valid_reg[k-1];
            valid_next[k] = advance[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = advance[0];
    assign out_valid = valid_reg[DEPTH-1];

    // ---------------------------------------------------------------- stage 1
    logic [23:0]        s1_d1_reg, s1_d1_next;
    logic signed [24:0] s1_dt_reg, s1_dt_next;

    // Offset of the raw temperature from the reference
    always_comb
    begin
        s1_d1_next = raw_pressure;
        s1_dt_next = $signed({1'b0, raw_temperature})
                   - $signed({1'b0, cal.reference_temperature, 8'd0});
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_d1_reg <= s1_d1_next;
            s1_dt_reg <= s1_dt_next;
        end
    end

    // ---------------------------------------------------------------- stage 2
    logic [23:0]        s2_d1_reg, s2_d1_next;
    logic signed [41:0] s2_tprod_reg, s2_tprod_next;
    logic [48:0]        s2_dtsq_reg, s2_dtsq_next;
    logic signed [41:0] s2_offprod_reg, s2_offprod_next;
    logic signed [41:0] s2_sensprod_reg, s2_sensprod_next;
    logic signed [49:0] dtsq_full;

    // Products of the temperature offset with itself and three coefficients
    always_comb
    begin
        s2_d1_next       = s1_d1_reg;
        s2_tprod_next    = s1_dt_reg * $signed({1'b0, cal.temperature_coef});
        dtsq_full        = s1_dt_reg * s1_dt_reg;
        s2_dtsq_next     = dtsq_full[48:0];
        s2_offprod_next  = s1_dt_reg * $signed({1'b0, cal.offset_temp_coef});
        s2_sensprod_next = s1_dt_reg * $signed({1'b0, cal.sensitivity_temp_coef});
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_d1_reg       <= s2_d1_next;
            s2_tprod_reg    <= s2_tprod_next;
            s2_dtsq_reg     <= s2_dtsq_next;
            s2_offprod_reg  <= s2_offprod_next;
            s2_sensprod_reg <= s2_sensprod_next;
        end
    end

    // ---------------------------------------------------------------- stage 3
    logic [23:0]        s3_d1_reg, s3_d1_next;
    logic signed [17:0] s3_q_reg, s3_q_next;
    logic [17:0]        s3_t2_reg, s3_t2_next;
    logic               s3_cold_reg, s3_cold_next;
    logic signed [37:0] s3_offa_reg, s3_offa_next;
    logic signed [36:0] s3_sensa_reg, s3_sensa_next;
    logic signed [41:0] tprod_adj;
    logic [50:0]        dtsq_x3;
    logic [50:0]        dtsq_x5;
    logic signed [41:0] offprod_adj;
    logic signed [41:0] sensprod_adj;
    logic [35:0]        offprod_quo;
    logic [34:0]        sensprod_quo;

    // Scale the products down with rounding toward zero; pick the T2 branch
    always_comb
    begin
        s3_d1_next   = s2_d1_reg;
        tprod_adj    = s2_tprod_reg + $signed({19'd0, {23{s2_tprod_reg[41]}}});
        s3_q_next    = tprod_adj[40:23];
        s3_cold_next = tprod_adj[40];

        dtsq_x3 = {2'b00, s2_dtsq_reg} + {1'b0, s2_dtsq_reg, 1'b0};
        dtsq_x5 = {2'b00, s2_dtsq_reg} + {s2_dtsq_reg, 2'b00};
        if (tprod_adj[40])
        begin
            s3_t2_next = dtsq_x3[50:33];
        end
        else
        begin
            s3_t2_next = {5'd0, dtsq_x5[50:38]};
        end

        offprod_adj  = s2_offprod_reg + $signed({36'd0, {6{s2_offprod_reg[41]}}});
        offprod_quo  = offprod_adj[41:6];
        s3_offa_next = $signed({5'd0, cal.pressure_offset, 17'd0})
                     + $signed({{2{offprod_quo[35]}}, offprod_quo});

        sensprod_adj  = s2_sensprod_reg + $signed({35'd0, {7{s2_sensprod_reg[41]}}});
        sensprod_quo  = sensprod_adj[41:7];
        s3_sensa_next = $signed({5'd0, cal.pressure_sensitivity, 16'd0})
                      + $signed({{2{sensprod_quo[34]}}, sensprod_quo});
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_d1_reg    <= s3_d1_next;
            s3_q_reg     <= s3_q_next;
            s3_t2_reg    <= s3_t2_next;
            s3_cold_reg  <= s3_cold_next;
            s3_offa_reg  <= s3_offa_next;
            s3_sensa_reg <= s3_sensa_next;
        end
    end

    // ---------------------------------------------------------------- stage 4
    logic [23:0]        s4_d1_reg, s4_d1_next;
    logic signed [18:0] s4_temp_reg, s4_temp_next;
    logic [33:0]        s4_losq_reg, s4_losq_next;
    logic [33:0]        s4_dlosq_reg, s4_dlosq_next;
    logic               s4_cold_reg, s4_cold_next;
    logic               s4_frigid_reg, s4_frigid_next;
    logic signed [37:0] s4_offa_reg, s4_offa_next;
    logic signed [36:0] s4_sensa_reg, s4_sensa_next;
    logic signed [19:0] temp_full;
    logic signed [35:0] losq_full;
    logic signed [18:0] dlo;
    logic signed [37:0] dlosq_full;

    // Final temperature and the squared distances below 20 and -15 degC
    always_comb
    begin
        s4_d1_next    = s3_d1_reg;
        temp_full     = bpc_pkg::TEMP_REF + $signed({{2{s3_q_reg[17]}}, s3_q_reg})
                      - $signed({2'b00, s3_t2_reg});
        s4_temp_next  = temp_full[18:0];
        losq_full     = s3_q_reg * s3_q_reg;
        s4_losq_next  = losq_full[33:0];
        dlo           = $signed({s3_q_reg[17], s3_q_reg}) + bpc_pkg::FRIGID_BIAS;
        dlosq_full    = dlo * dlo;
        s4_dlosq_next = dlosq_full[33:0];
        s4_cold_next  = s3_cold_reg;
        s4_frigid_next = s3_q_reg < bpc_pkg::FRIGID_LIMIT;
        s4_offa_next  = s3_offa_reg;
        s4_sensa_next = s3_sensa_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_d1_reg     <= s4_d1_next;
            s4_temp_reg   <= s4_temp_next;
            s4_losq_reg   <= s4_losq_next;
            s4_dlosq_reg  <= s4_dlosq_next;
            s4_cold_reg   <= s4_cold_next;
            s4_frigid_reg <= s4_frigid_next;
            s4_offa_reg   <= s4_offa_next;
            s4_sensa_reg  <= s4_sensa_next;
        end
    end

    // ---------------------------------------------------------------- stage 5
    logic [23:0]        s5_d1_reg, s5_d1_next;
    logic signed [18:0] s5_temp_reg, s5_temp_next;
    logic [39:0]        s5_off2_reg, s5_off2_next;
    logic [39:0]        s5_sens2_reg, s5_sens2_next;
    logic signed [37:0] s5_offa_reg, s5_offa_next;
    logic signed [36:0] s5_sensa_reg, s5_sensa_next;
    logic [39:0]        losq_x61;
    logic [38:0]        losq_x29;
    logic [38:0]        dlosq_x17;
    logic [37:0]        dlosq_x9;
    logic [39:0]        off2_frigid;
    logic [39:0]        sens2_frigid;

    // Second-order offset and sensitivity corrections
    always_comb
    begin
        s5_d1_next    = s4_d1_reg;
        s5_temp_next  = s4_temp_reg;
        s5_offa_next  = s4_offa_reg;
        s5_sensa_next = s4_sensa_reg;

        losq_x61  = {6'd0, s4_losq_reg} * 40'd61;
        losq_x29  = {5'd0, s4_losq_reg} * 39'd29;
        dlosq_x17 = {5'd0, s4_dlosq_reg} * 39'd17;
        dlosq_x9  = {4'd0, s4_dlosq_reg} * 38'd9;

        off2_frigid  = s4_frigid_reg ? {1'b0, dlosq_x17} : '0;
        sens2_frigid = s4_frigid_reg ? {2'b00, dlosq_x9} : '0;

        if (s4_cold_reg)
        begin
            s5_off2_next  = {4'd0, losq_x61[39:4]} + off2_frigid;
            s5_sens2_next = {5'd0, losq_x29[38:4]} + sens2_frigid;
        end
        else
        begin
            s5_off2_next  = '0;
            s5_sens2_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_d1_reg    <= s5_d1_next;
            s5_temp_reg  <= s5_temp_next;
            s5_off2_reg  <= s5_off2_next;
            s5_sens2_reg <= s5_sens2_next;
            s5_offa_reg  <= s5_offa_next;
            s5_sensa_reg <= s5_sensa_next;
        end
    end

    // ---------------------------------------------------------------- stage 6
    logic [23:0]        s6_d1_reg, s6_d1_next;
    logic signed [18:0] s6_temp_reg, s6_temp_next;
    logic signed [41:0] s6_off_reg, s6_off_next;
    logic signed [41:0] s6_sens_reg, s6_sens_next;

    // Apply the corrections to offset and sensitivity
    always_comb
    begin
        s6_d1_next   = s5_d1_reg;
        s6_temp_next = s5_temp_reg;
        s6_off_next  = $signed({{4{s5_offa_reg[37]}}, s5_offa_reg})
                     - $signed({2'b00, s5_off2_reg});
        s6_sens_next = $signed({{5{s5_sensa_reg[36]}}, s5_sensa_reg})
                     - $signed({2'b00, s5_sens2_reg});
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            s6_d1_reg   <= s6_d1_next;
            s6_temp_reg <= s6_temp_next;
            s6_off_reg  <= s6_off_next;
            s6_sens_reg <= s6_sens_next;
        end
    end

    // ---------------------------------------------------------------- stage 7
    logic signed [18:0] s7_temp_reg, s7_temp_next;
    logic signed [41:0] s7_off_reg, s7_off_next;
    logic [44:0]        s7_pplo_reg, s7_pplo_next;
    logic signed [45:0] s7_pphi_reg, s7_pphi_next;

    // Split the pressure product into low and high partial products
    always_comb
    begin
        s7_temp_next = s6_temp_reg;
        s7_off_next  = s6_off_reg;
        s7_pplo_next = s6_d1_reg * s6_sens_reg[20:0];
        s7_pphi_next = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[41:21]);
    end

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            s7_temp_reg <= s7_temp_next;
            s7_off_reg  <= s7_off_next;
            s7_pplo_reg <= s7_pplo_next;
            s7_pphi_reg <= s7_pphi_next;
        end
    end

    // ---------------------------------------------------------------- stage 8
    logic signed [18:0] s8_temp_reg, s8_temp_next;
    logic signed [41:0] s8_off_reg, s8_off_next;
    logic signed [45:0] s8_floor_reg, s8_floor_next;
    logic               s8_inexact_reg, s8_inexact_next;

    // Floor of the product over 2^21; the low partial product holds the remainder
    always_comb
    begin
        s8_temp_next    = s7_temp_reg;
        s8_off_next     = s7_off_reg;
        s8_floor_next   = s7_pphi_reg + $signed({22'd0, s7_pplo_reg[44:21]});
        s8_inexact_next = |s7_pplo_reg[20:0];
    end

    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            s8_temp_reg    <= s8_temp_next;
            s8_off_reg     <= s8_off_next;
            s8_floor_reg   <= s8_floor_next;
            s8_inexact_reg <= s8_inexact_next;
        end
    end

    // ---------------------------------------------------------------- stage 9
    logic signed [18:0] s9_temp_reg, s9_temp_next;
    logic signed [46:0] s9_x_reg, s9_x_next;
    logic               round_up;

    // Turn the floor into a truncation toward zero and remove the offset
    always_comb
    begin
        s9_temp_next = s8_temp_reg;
        round_up     = s8_floor_reg[45] && s8_inexact_reg;
        s9_x_next    = $signed({s8_floor_reg[45], s8_floor_reg})
                     + $signed({46'd0, round_up})
                     - $signed({{5{s8_off_reg[41]}}, s8_off_reg});
    end

    always_ff @(posedge clk)
    begin
        if (load[8])
        begin
            s9_temp_reg <= s9_temp_next;
            s9_x_reg    <= s9_x_next;
        end
    end

    // ---------------------------------------------------------------- stage 10
    logic signed [18:0] s10_temp_reg, s10_temp_next;
    logic signed [31:0] s10_pres_reg, s10_pres_next;
    logic signed [46:0] x_adj;

    // Final scaling; a 47-bit value over 2^15 always fits the 32-bit result
    always_comb
    begin
        s10_temp_next = s9_temp_reg;
        x_adj         = s9_x_reg + $signed({32'd0, {15{s9_x_reg[46]}}});
        s10_pres_next = x_adj[46:15];
    end

    always_ff @(posedge clk)
    begin
        if (load[9])
        begin
            s10_temp_reg <= s10_temp_next;
            s10_pres_reg <= s10_pres_next;
        end
    end

    assign temperature_centi = s10_temp_reg;
    assign pressure_centi    = s10_pres_reg;

endmodule

/* src/bpc_checker.sv */
// Port-level checker for the pressure compensation block, with its bind
`include "barometric_pressure_compensation_macros.svh"

module bpc_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [bpc_pkg::TEMP_WIDTH-1:0]  temperature_centi,
    input  logic signed [bpc_pkg::PRES_WIDTH-1:0]  pressure_centi
);

    localparam int unsigned DEPTH   = bpc_pkg::PIPE_DEPTH;
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_take;
    logic             out_take;

    // Track requests taken but not yet delivered
    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_take && !out_take)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!in_take && out_take)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `BPC_ASSERT_NOW(a_no_orphan_result, out_valid, count_reg != '0, "result with no pending request")
    `BPC_ASSERT_NOW(a_depth_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "more requests held than stages")
    `BPC_ASSERT_NOW(a_ready_when_empty, count_reg == '0, in_ready, "empty pipeline refuses a request")
    `BPC_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(temperature_centi) && $stable(pressure_centi), "stalled result changed")

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_centi (temperature_centi),
    .pressure_centi    (pressure_centi)
);

/* sim/barometric_pressure_compensation_test.sv */
// Self-checking testbench for the barometric pressure compensation pipeline
`timescale 1ns / 1ps

module barometric_pressure_compensation_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_WAIT     = 18;
    localparam int RAW_MAX      = 16777215;
    localparam int RANDOM_SETS  = 6;
    localparam int SET_REQUESTS = 110;

    typedef logic [bpc_pkg::RAW_WIDTH-1:0] raw_word_t;
    typedef logic [bpc_pkg::CAL_WIDTH-1:0] cal_word_t;

    // Indexes past the last calibration word; writes there must be dropped
    localparam logic [bpc_pkg::CFG_INDEX_WIDTH-1:0] SPARE_INDEX_LOW  = 3'd6;
    localparam logic [bpc_pkg::CFG_INDEX_WIDTH-1:0] SPARE_INDEX_HIGH = 3'd7;

    // Temperature thresholds of the correction branches, in 0.01 degC
    localparam longint ROOM_CENTI   = 2000;
    localparam longint FRIGID_CENTI = -1500;

    typedef struct packed {
        logic [bpc_pkg::RAW_WIDTH-1:0] pressure;
        logic [bpc_pkg::RAW_WIDTH-1:0] temperature;
    } raw_pair_t;

    typedef struct packed {
        logic signed [bpc_pkg::TEMP_WIDTH-1:0] temperature;
        logic signed [bpc_pkg::PRES_WIDTH-1:0] pressure;
    } reading_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  cfg_valid = 1'b0;
    logic                                  cfg_ready;
    logic [bpc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index = '0;
    logic [bpc_pkg::CAL_WIDTH-1:0]         cfg_data = '0;
    logic                                  in_valid = 1'b0;
    logic                                  in_ready;
    logic [bpc_pkg::RAW_WIDTH-1:0]         raw_pressure = '0;
    logic [bpc_pkg::RAW_WIDTH-1:0]         raw_temperature = '0;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic signed [bpc_pkg::TEMP_WIDTH-1:0] temperature_centi;
    logic signed [bpc_pkg::PRES_WIDTH-1:0] pressure_centi;

    raw_pair_t      raw_backlog[$];
    reading_t       awaited_readings[$];
    bpc_pkg::cal_t  cal_model = '0;

    int requests_taken = 0;
    int results_taken  = 0;
    int failures       = 0;
    int cycle_count    = 0;

    barometric_pressure_compensation dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .raw_pressure      (raw_pressure),
        .raw_temperature   (raw_temperature),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .temperature_centi (temperature_centi),
        .pressure_centi    (pressure_centi)
    );

    always #5 clk = ~clk;

    // Second-order compensation of one reading pair, 64-bit signed, truncating shifts
    function automatic reading_t compensate_reading(bpc_pkg::cal_t cal,
                                                    logic [bpc_pkg::RAW_WIDTH-1:0] d1_raw,
                                                    logic [bpc_pkg::RAW_WIDTH-1:0] d2_raw);
        longint d1, dt, temp, t2, off2, sens2, below, frigid, off, sens, p;
        reading_t result;
        d1   = longint'(d1_raw);
        dt   = longint'(d2_raw) - longint'(cal.reference_temperature) * 256;
        temp = ROOM_CENTI + (dt * longint'(cal.temperature_coef)) / (longint'(1) << 23);
        if (temp < ROOM_CENTI)
        begin
            below = temp - ROOM_CENTI;
            t2    = (3 * dt * dt) / (longint'(1) << 33);
            off2  = (61 * below * below) / 16;
            sens2 = (29 * below * below) / 16;
            // extra term in the very cold range
            if (temp < FRIGID_CENTI)
            begin
                frigid = temp - FRIGID_CENTI;
                off2   = off2 + 17 * frigid * frigid;
                sens2  = sens2 + 9 * frigid * frigid;
            end
        end
        else
        begin
            t2    = (5 * dt * dt) / (longint'(1) << 38);
            off2  = 0;
            sens2 = 0;
        end
        temp = temp - t2;
        off  = longint'(cal.pressure_offset) * (longint'(1) << 17)
             + (longint'(cal.offset_temp_coef) * dt) / 64 - off2;
        sens = longint'(cal.pressure_sensitivity) * (longint'(1) << 16)
             + (longint'(cal.sensitivity_temp_coef) * dt) / 128 - sens2;
        p = ((d1 * sens) / (longint'(1) << 21) - off) / (longint'(1) << 15);
        // saturate to 32 bits
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        result.temperature = temp[bpc_pkg::TEMP_WIDTH-1:0];
        result.pressure    = p[bpc_pkg::PRES_WIDTH-1:0];
        return result;
    endfunction

    // Wait length before the next transfer, with occasional runs of none at all
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Drive requests from the backlog; hold each one until it is taken
    always @(negedge clk)
    begin : drive_requests
        raw_pair_t next_pair;
        int requests_sent;
        int send_wait;
        int send_calm;
        if (rst_n)
        begin
            if (in_valid && requests_taken != requests_sent)
                in_valid <= 1'b1;
            else if (send_wait > 0)
            begin
                send_wait = send_wait - 1;
                in_valid <= 1'b0;
            end
            else if (raw_backlog.size() != 0)
            begin
                next_pair = raw_backlog.pop_front();
                raw_pressure    <= next_pair.pressure;
                raw_temperature <= next_pair.temperature;
                in_valid        <= 1'b1;
                requests_sent = requests_sent + 1;
                send_wait = draw_wait(send_calm);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Stall the result channel after each result, for a wait drawn by draw_wait
    always @(negedge clk)
    begin : drive_result_ready
        int results_seen;
        int recv_wait;
        int recv_calm;
        if (results_taken != results_seen)
        begin
            results_seen = results_taken;
            recv_wait = draw_wait(recv_calm);
        end
        if (recv_wait > 0)
        begin
            recv_wait = recv_wait - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n;
    end

    // Track calibration writes, predict each request and check each result
    always @(posedge clk)
    begin : watch_channels
        reading_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bpc_pkg::REG_PRESSURE_SENSITIVITY:
                        cal_model.pressure_sensitivity  = cfg_data;
                    bpc_pkg::REG_PRESSURE_OFFSET:
                        cal_model.pressure_offset       = cfg_data;
                    bpc_pkg::REG_SENSITIVITY_TEMP_COEF:
                        cal_model.sensitivity_temp_coef = cfg_data;
                    bpc_pkg::REG_OFFSET_TEMP_COEF:
                        cal_model.offset_temp_coef      = cfg_data;
                    bpc_pkg::REG_REFERENCE_TEMPERATURE:
                        cal_model.reference_temperature = cfg_data;
                    bpc_pkg::REG_TEMPERATURE_COEF:
                        cal_model.temperature_coef      = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                results_taken = results_taken + 1;
                if (awaited_readings.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got temperature %0d pressure %0d",
                             $time, temperature_centi, pressure_centi);
                    failures = failures + 1;
                end
                else
                begin
                    want = awaited_readings.pop_front();
                    if (temperature_centi !== want.temperature)
                    begin
                        $display("%0t: temperature_centi mismatch, expected %0d, got %0d",
                                 $time, $signed(want.temperature), temperature_centi);
                        failures = failures + 1;
                    end
                    if (pressure_centi !== want.pressure)
                    begin
                        $display("%0t: pressure_centi mismatch, expected %0d, got %0d",
                                 $time, $signed(want.pressure), pressure_centi);
                        failures = failures + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                awaited_readings.push_back(compensate_reading(cal_model, raw_pressure,
                                                              raw_temperature));
                requests_taken = requests_taken + 1;
            end
        end
    end

    // End the run if it hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("barometric_pressure_compensation test failed");
        $finish;
    end

    task automatic write_cal(input logic [bpc_pkg::CFG_INDEX_WIDTH-1:0] index,
                             input logic [bpc_pkg::CAL_WIDTH-1:0] value);
        @(negedge clk);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Write all six calibration words, then two writes that must be dropped
    task automatic load_cal(input bpc_pkg::cal_t cal);
        write_cal(bpc_pkg::REG_PRESSURE_SENSITIVITY, cal.pressure_sensitivity);
        write_cal(bpc_pkg::REG_PRESSURE_OFFSET, cal.pressure_offset);
        write_cal(bpc_pkg::REG_SENSITIVITY_TEMP_COEF, cal.sensitivity_temp_coef);
        write_cal(bpc_pkg::REG_OFFSET_TEMP_COEF, cal.offset_temp_coef);
        write_cal(bpc_pkg::REG_REFERENCE_TEMPERATURE, cal.reference_temperature);
        write_cal(bpc_pkg::REG_TEMPERATURE_COEF, cal.temperature_coef);
        write_cal(SPARE_INDEX_LOW, cal_word_t'($urandom));
        write_cal(SPARE_INDEX_HIGH, cal_word_t'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pair(input logic [bpc_pkg::RAW_WIDTH-1:0] d1,
                              input logic [bpc_pkg::RAW_WIDTH-1:0] d2);
        raw_pair_t pair;
        pair.pressure    = d1;
        pair.temperature = d2;
        raw_backlog.push_back(pair);
    endtask

    // Hold off until every request has been answered and the pipeline is empty
    task automatic settle();
        while (raw_backlog.size() != 0 || in_valid || awaited_readings.size() != 0)
            @(posedge clk);
        repeat (bpc_pkg::PIPE_DEPTH + 2) @(posedge clk);
    endtask

    initial
    begin
        bpc_pkg::cal_t                 cal_set;
        logic [bpc_pkg::RAW_WIDTH-1:0] d1;
        logic [bpc_pkg::RAW_WIDTH-1:0] d2;
        longint                        near;
        int                            base;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // calibration still at reset: all words zero
        queue_pair(24'd0, 24'd0);
        queue_pair(24'hFFFFFF, 24'hFFFFFF);
        queue_pair(24'hFFFFFF, 24'd0);
        queue_pair(24'd0, 24'hFFFFFF);
        settle();

        // typical calibration: room, cold, frigid and hot readings
        cal_set = '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};
        load_cal(cal_set);
        queue_pair(24'd6465444, 24'd8077636);
        queue_pair(24'd0, 24'd0);
        queue_pair(24'hFFFFFF, 24'd0);
        queue_pair(24'hFFFFFF, 24'hFFFFFF);
        queue_pair(24'd0, 24'hFFFFFF);
        queue_pair(24'd8388608, 24'd8077568);
        queue_pair(24'd5000000, 24'd4000000);
        settle();

        // unit temperature slope: land exactly on both branch thresholds
        cal_set = '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'h8000, 16'h8000};
        load_cal(cal_set);
        queue_pair(24'd6465444, 24'h800000 - 24'd255);
        queue_pair(24'd6465444, 24'h800000 - 24'd256);
        queue_pair(24'd6465444, 24'h800000 - 24'd896255);
        queue_pair(24'd6465444, 24'h800000 - 24'd896256);
        queue_pair(24'd6465444, 24'd0);
        queue_pair(24'd6465444, 24'hFFFFFF);
        settle();

        // every word at its maximum
        cal_set = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        load_cal(cal_set);
        queue_pair(24'd0, 24'd0);
        queue_pair(24'hFFFFFF, 24'hFFFFFF);
        queue_pair(24'hFFFFFF, 24'd0);
        queue_pair(24'd0, 24'hFFFFFF);
        settle();

        // random calibrations, each with a batch of random readings
        for (int set_no = 0; set_no < RANDOM_SETS; set_no++)
        begin
            cal_set = {$urandom, $urandom, $urandom};
            for (int word = 0; word < 6; word++)
            begin
                case ($urandom_range(0, 5))
                    0: cal_set[word*bpc_pkg::CAL_WIDTH +: bpc_pkg::CAL_WIDTH] = '0;
                    1: cal_set[word*bpc_pkg::CAL_WIDTH +: bpc_pkg::CAL_WIDTH] = '1;
                    default: ;
                endcase
            end
            load_cal(cal_set);
            base = int'(cal_set.reference_temperature) * 256;
            for (int n = 0; n < SET_REQUESTS; n++)
            begin
                d1 = raw_word_t'($urandom);
                case ($urandom_range(0, 3))
                    0: d2 = raw_word_t'($urandom);
                    1:
                    begin
                        // close to the reference, around the branch thresholds
                        near = longint'(base) + longint'($urandom_range(0, 262143)) - 131072;
                        if (near < 0)
                            near = 0;
                        if (near > RAW_MAX)
                            near = RAW_MAX;
                        d2 = near[bpc_pkg::RAW_WIDTH-1:0];
                    end
                    2: d2 = raw_word_t'($urandom_range(0, base));
                    default: d2 = raw_word_t'($urandom_range(base, RAW_MAX));
                endcase
                queue_pair(d1, d2);
            end
            settle();
        end

        if (failures == 0)
            $display("barometric_pressure_compensation test passed");
        else
            $display("barometric_pressure_compensation test failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/bpc_pkg.sv
src/bpc_cfg.sv
src/barometric_pressure_compensation.sv
src/bpc_checker.sv
sim/barometric_pressure_compensation_test.sv
